FILE: design/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; used by every file of the block.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int ADDR_W = 11;
  localparam int CHAR_W = 8;
  localparam int DATA_W = 16;

  localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MEM
  } state_e;

endpackage

FILE: design/tcw_cell_ram.sv
// Cell buffer of the text console writer: one write port, one read port
// with registered read data. Depends on tcw_pkg for the cell width.
module tcw_cell_ram #(
  parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [tcw_pkg::DATA_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [tcw_pkg::DATA_W-1:0] rdata_o
);

  logic [tcw_pkg::DATA_W-1:0] mem [DEPTH];
  logic [tcw_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/text_console_writer.sv
// Top level of the text console writer: sequencer, cursor and result register.
// Depends on tcw_pkg and tcw_cell_ram.
//
// Every request, put or read, is handled in order: first the addressed cell is read from
// the cell buffer, then a put of any code but newline writes the modified cell back and
// the result register is loaded. A new request is taken while the previous result still
// waits, but the second step waits for the result register to be free. After reset, and
// after any put that moves the cursor past the last row, the buffer is swept
// one cell per cycle, over all COLUMNS*ROWS cells (2000 at the default size), while
// input requests are stalled.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [tcw_pkg::ADDR_W-1:0]  cell_address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tcw_pkg::COL_W-1:0]   cursor_column_o,
  output logic [tcw_pkg::ROW_W-1:0]   cursor_row_o,
  output logic [tcw_pkg::DATA_W-1:0]  cell_data_o,
  output logic                        screen_cleared_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW = $clog2(CELLS);
  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int XW = (AW > tcw_pkg::ADDR_W) ? AW : tcw_pkg::ADDR_W;
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  tcw_pkg::state_e state_q, state_d;

  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic                       kind_q;
  logic [tcw_pkg::CHAR_W-1:0] code_q;
  logic                       addr_ok_q;
  logic [AW-1:0]              idx_q;

  logic                        out_valid_q;
  logic [tcw_pkg::COL_W-1:0]   out_col_q;
  logic [tcw_pkg::ROW_W-1:0]   out_row_q;
  logic [tcw_pkg::DATA_W-1:0]  out_data_q;
  logic                        out_clr_q;

  logic [XW-1:0]              addr_ext;
  logic [AW-1:0]              cur_idx;
  logic                       accept;
  logic                       out_free;
  logic                       finish;
  logic                       clr_last;
  logic                       is_put;
  logic                       is_nl;
  logic [CW:0]                col_inc;
  logic                       col_wrap;
  logic [RW:0]                row_inc;
  logic                       row_adv;
  logic                       clear_hit;
  logic [CW-1:0]              col_nx;
  logic [RW-1:0]              row_nx;
  logic [tcw_pkg::DATA_W-1:0] rdata;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [tcw_pkg::DATA_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;

  assign addr_ext = XW'(cell_address_i);
  assign cur_idx = AW'(row_q) * COLS_A + AW'(col_q);
  assign accept = in_valid_i && (state_q == tcw_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish = (state_q == tcw_pkg::ST_MEM) && out_free;
  assign clr_last = (clr_q == LAST_CELL);

  assign is_put = (kind_q == tcw_pkg::KIND_PUT);
  assign is_nl = (code_q == tcw_pkg::NEWLINE_CODE);
  assign col_inc = {1'b0, col_q} + (CW+1)'(1);
  assign col_wrap = !is_nl && (col_inc == (CW+1)'(COLUMNS));
  assign row_adv = is_nl || col_wrap;
  assign row_inc = {1'b0, row_q} + (RW+1)'(1);
  assign clear_hit = is_put && row_adv && (row_inc == (RW+1)'(ROWS));
  assign col_nx = row_adv ? '0 : col_inc[CW-1:0];
  assign row_nx = clear_hit ? '0 : (row_adv ? row_inc[RW-1:0] : row_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tcw_pkg::ST_MEM;
        end
      end
      tcw_pkg::ST_MEM: begin
        if (out_free) begin
          state_d = clear_hit ? tcw_pkg::ST_CLEAR : tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = {rdata[tcw_pkg::DATA_W-1:tcw_pkg::CHAR_W], code_q};
    ram_re = accept;
    ram_raddr = (kind_i == tcw_pkg::KIND_READ) ? addr_ext[AW-1:0] : cur_idx;
    clr_d = clr_q;
    col_d = col_q;
    row_d = row_q;
    case (state_q)
      tcw_pkg::ST_CLEAR: begin
        // Attributes are never changed after reset, so the sweep writes
        // the reset cell.
        ram_we = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = tcw_pkg::BLANK_CELL;
        clr_d = clr_q + AW'(1);
      end
      tcw_pkg::ST_MEM: begin
        if (finish && is_put) begin
          ram_we = !is_nl;
          col_d = col_nx;
          row_d = row_nx;
          clr_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o = (state_q != tcw_pkg::ST_IDLE);

  tcw_cell_ram #(
    .DEPTH(CELLS),
    .AW(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_CLEAR;
      clr_q <= '0;
      col_q <= '0;
      row_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      col_q <= col_d;
      row_q <= row_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      code_q <= char_code_i;
      addr_ok_q <= (32'(cell_address_i) < 32'(CELLS));
      idx_q <= cur_idx;
    end
    if (finish) begin
      out_col_q <= tcw_pkg::COL_W'(is_put ? col_nx : col_q);
      out_row_q <= tcw_pkg::ROW_W'(is_put ? row_nx : row_q);
      out_data_q <= (!is_put && addr_ok_q) ? rdata : '0;
      out_clr_q <= clear_hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cursor_column_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign cell_data_o = out_data_q;
  assign screen_cleared_o = out_clr_q;

endmodule

FILE: design/tcw_checker.sv
// Port-level checks for the text console writer, with the bind that attaches
// them to text_console_writer. Depends on tcw_pkg for field widths.
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [tcw_pkg::COL_W-1:0]  cursor_column_o,
  input logic [tcw_pkg::ROW_W-1:0]  cursor_row_o,
  input logic [tcw_pkg::DATA_W-1:0] cell_data_o,
  input logic                       screen_cleared_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cursor_column_o) &&
    $stable(cursor_row_o) && $stable(cell_data_o) && $stable(screen_cleared_o))
    else $error("result changed while stalled");

  a_clear_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && screen_cleared_o |->
    cursor_column_o == '0 && cursor_row_o == '0 && cell_data_o == '0)
    else $error("screen clear without homed cursor");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while previous one is in progress");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(cursor_column_o) < COLUMNS && 32'(cursor_row_o) < ROWS)
    else $error("cursor outside the screen");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS(ROWS)
) u_tcw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .cursor_column_o (cursor_column_o),
  .cursor_row_o    (cursor_row_o),
  .cell_data_o     (cell_data_o),
  .screen_cleared_o(screen_cleared_o)
);
